// ===== hw/rtl/dq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Field widths, action codes, sequencer states and the default depth.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int ACTION_W      = 3;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 7;

  // Peek value reported on an empty queue
  localparam logic [VALUE_W-1:0] EMPTY_PEEK = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REPORT     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage : dq_pkg
`default_nettype wire

// ===== hw/rtl/dq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if: request and response channels of the queue
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface dq_req_if;
  import dq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface : dq_req_if

interface dq_rsp_if;
  import dq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;

  modport source (output valid, output accepted, output front_value, output back_value,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input accepted, input front_value, input back_value,
                  input entry_count, input is_empty, output ready);
endinterface : dq_rsp_if
`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values in a ring buffer
//
// Channels: req carries one action (push front, push back, pop front,
// pop back, report) and a value; rsp returns one result per request:
// accepted flag, front and back values (-1 when empty), entry count and
// an empty flag. Rejected pushes (full) and pops (empty) change nothing.
//
// Timing: a request moves through the accept, read and load steps on its
// way to the result register. Accept writes the slot store and moves the
// pointers; read fetches the front and back slots from the synchronous
// RAM; load writes the result. One request is in flight at a time: no new
// transaction is taken until the last one has loaded its result.
//
// A result waits in the output register while rsp.ready is low; a new
// request is still taken meanwhile and holds in its load step until the
// output register frees up.
// Reset clears the pointers and count (empty queue) and holds req.ready
// low; the slot store is not cleared, since no slot is read before it is
// written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  dq_req_if.sink    req,
  dq_rsp_if.source  rsp
);
  import dq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Pointer and count registers
  logic [IDX_W-1:0] head_index, head_index_next;
  logic [IDX_W-1:0] tail_index, tail_index_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic             ok, ok_next;

  state_t state, state_next;

  // Slot store and its registered read data
  logic [VALUE_W-1:0] slot_store [DEPTH];
  logic [VALUE_W-1:0] rd_front, rd_back;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   tail_prev;

  logic accept, rd_en, out_load, out_free;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  assign out_free  = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign tail_prev = idx_dec(tail_index);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: req.ready = !rst;
      ST_READ: rd_en     = 1'b1;
      ST_LOAD: out_load  = out_free;
      default: ;
    endcase
  end

  // Action decode: pointer moves, count update and slot write
  always_comb begin
    logic full, empty;
    full              = (stored_count == CNT_FULL);
    empty             = (stored_count == '0);
    head_index_next   = head_index;
    tail_index_next   = tail_index;
    stored_count_next = stored_count;
    ok_next           = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = tail_index;
    case (action_t'(req.action))
      ACT_PUSH_FRONT: if (!full) begin
        head_index_next   = idx_dec(head_index);
        wr_addr           = head_index_next;
        wr_en             = 1'b1;
        stored_count_next = stored_count + CNT_W'(1);
        ok_next           = 1'b1;
      end
      ACT_PUSH_BACK: if (!full) begin
        tail_index_next   = idx_inc(tail_index);
        wr_addr           = tail_index;
        wr_en             = 1'b1;
        stored_count_next = stored_count + CNT_W'(1);
        ok_next           = 1'b1;
      end
      ACT_POP_FRONT: if (!empty) begin
        head_index_next   = idx_inc(head_index);
        stored_count_next = stored_count - CNT_W'(1);
        ok_next           = 1'b1;
      end
      ACT_POP_BACK: if (!empty) begin
        tail_index_next   = tail_prev;
        stored_count_next = stored_count - CNT_W'(1);
        ok_next           = 1'b1;
      end
      ACT_REPORT: ok_next = 1'b1;
      default:    ok_next = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head_index   <= '0;
      tail_index   <= '0;
      stored_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        head_index   <= head_index_next;
        tail_index   <= tail_index_next;
        stored_count <= stored_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ok <= ok_next;
  end

  // Slot store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && wr_en) slot_store[wr_addr] <= req.value;
    if (rd_en) begin
      rd_front <= slot_store[head_index];
      rd_back  <= slot_store[tail_prev];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.accepted    <= ok;
      rsp.front_value <= (stored_count == '0) ? EMPTY_PEEK : rd_front;
      rsp.back_value  <= (stored_count == '0) ? EMPTY_PEEK : rd_back;
      rsp.entry_count <= COUNT_W'(stored_count);
      rsp.is_empty    <= (stored_count == '0);
    end
  end

endmodule : double_ended_queue
`default_nettype wire
